FILE: sv/pbts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Priority bitmap task scheduler package
// Shared types and codes for the scheduler and its checker.
// ----------------------------------------------------------------------------
package pbts_pkg;

    localparam int GROUP_SIZE = 8;

    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_ATTACH   = 3'd1,
        MODE_UNBLOCK  = 3'd2,
        MODE_DETACH   = 3'd3,
        MODE_SLEEP    = 3'd4,
        MODE_SCHEDULE = 3'd5,
        MODE_SPARE6   = 3'd6,
        MODE_SPARE7   = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_READY = 2'd1,
        STAT_BAD_TASK = 2'd2
    } result_status_t;

    typedef enum logic [1:0] {
        TS_INACTIVE = 2'd0,
        TS_READY    = 2'd1,
        TS_SLEEP    = 2'd2
    } task_state_t;

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_DISP    = 19'h00002,
        S_PT_RD   = 19'h00004,
        S_PT_WR   = 19'h00008,
        S_PT_LNK  = 19'h00010,
        S_PH_RD   = 19'h00020,
        S_PH_WR   = 19'h00040,
        S_PH_LNK  = 19'h00080,
        S_UL_RD   = 19'h00100,
        S_UL_LAT  = 19'h00200,
        S_UL_WR   = 19'h00400,
        S_SC_CHK  = 19'h00800,
        S_SC_RD   = 19'h01000,
        S_SC_CMP  = 19'h02000,
        S_SC_INC  = 19'h04000,
        S_LOOK    = 19'h08000,
        S_SEL_RD  = 19'h10000,
        S_SEL_CHK = 19'h20000,
        S_FIN     = 19'h40000
    } state_t;

endpackage
`default_nettype wire

FILE: sv/pbts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/priority_bitmap_task_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Priority bitmap task scheduler
// Ready queues per priority kept as linked lists in RAM, with a bitmap lookup.
// ----------------------------------------------------------------------------
// Init, attach, unblock and detach or sleep of a ready task update the queues; rejected events,
// the other detach and sleep cases and modes six and seven leave them as they are. Schedule
// scans every task id, wakes each sleeping task whose wake time is before now, picks the
// best queue's head, skips it if it is current, and rotates the pick to its queue's tail.
// A new transfer is taken in the cycle after the strobe; the receiver cannot stall done.
// Reset empties all queues, marks every task inactive and sets task zero current.
module priority_bitmap_task_scheduler #(
    parameter int NUM_PRIORITIES = 64,
    parameter int MAX_TASKS      = 32,
    parameter int TIME_BITS      = 48
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [2:0]           mode,
    input  wire logic [4:0]           task_id,
    input  wire logic [5:0]           priority_req,
    input  wire logic [TIME_BITS-1:0] wake_time,
    input  wire logic [TIME_BITS-1:0] now,
    output logic                      done,
    output logic                      switched,
    output logic [4:0]                active_task,
    output logic [4:0]                prev_task,
    output logic [5:0]                chosen_priority,
    output logic [1:0]                status
);
    import pbts_pkg::*;

    localparam int IW   = $clog2(MAX_TASKS);
    localparam int TW   = $clog2(MAX_TASKS + 1);
    localparam int PW   = $clog2(NUM_PRIORITIES);
    localparam int ROWS = (NUM_PRIORITIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam logic [TW-1:0] NIL = TW'(MAX_TASKS);

    state_t                state_reg, state_next;
    state_t                ret_reg, ret_next;
    logic [2:0]            mode_reg, mode_next;
    logic [4:0]            tid_reg, tid_next;
    logic [5:0]            preq_reg, preq_next;
    logic [TIME_BITS-1:0]  wake_reg, wake_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic [IW-1:0]         prev_reg, prev_next;
    logic [IW-1:0]         ta_reg, ta_next;
    logic [PW-1:0]         pa_reg, pa_next;
    logic [TW-1:0]         pr_reg, pr_next;
    logic [TW-1:0]         nx_reg, nx_next;
    logic [IW-1:0]         scan_reg, scan_next;
    logic                  from_head_reg, from_head_next;
    logic                  sw_reg, sw_next;
    logic [PW-1:0]         chosen_reg, chosen_next;
    logic [1:0]            stat_reg, stat_next;
    logic [NUM_PRIORITIES-1:0] rb_reg, rb_next;
    task_state_t           st_reg [MAX_TASKS];
    task_state_t           st_next [MAX_TASKS];

    logic                  head_we, tail_we, next_we, prev_we, prio_we, wake_we;
    logic [PW-1:0]         head_wa, tail_wa;
    logic [IW-1:0]         next_wa, prev_wa, prio_wa, wake_wa;
    logic [TW-1:0]         head_wd, tail_wd, next_wd, prev_wd;
    logic [PW-1:0]         prio_wd;
    logic [TW-1:0]         head_q, tail_q, next_q, prev_q;
    logic [PW-1:0]         prio_q;
    logic [TIME_BITS-1:0]  wake_q;

    logic [ROWS*GROUP_SIZE-1:0] rb_pad;
    logic [ROWS-1:0]            group;
    logic [PW-1:0]              best_prio;

    pbts_ram #(.WIDTH(TW), .DEPTH(NUM_PRIORITIES)) u_head (
        .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
        .raddr(pa_reg), .rdata(head_q)
    );
    pbts_ram #(.WIDTH(TW), .DEPTH(NUM_PRIORITIES)) u_tail (
        .clk(clk), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd),
        .raddr(pa_reg), .rdata(tail_q)
    );
    pbts_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_next (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(ta_reg), .rdata(next_q)
    );
    pbts_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_prev (
        .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .raddr(ta_reg), .rdata(prev_q)
    );
    pbts_ram #(.WIDTH(PW), .DEPTH(MAX_TASKS)) u_prio (
        .clk(clk), .we(prio_we), .waddr(prio_wa), .wdata(prio_wd),
        .raddr(ta_reg), .rdata(prio_q)
    );
    pbts_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_wake (
        .clk(clk), .we(wake_we), .waddr(wake_wa), .wdata(wake_reg),
        .raddr(ta_reg), .rdata(wake_q)
    );

    // Two-level lookup: lowest non-empty row, then lowest bit in that row.
    always_comb
    begin
        int row;
        int bitpos;
        logic [GROUP_SIZE-1:0] row_byte;
        rb_pad = (ROWS*GROUP_SIZE)'(rb_reg);
        row = 0;
        bitpos = 0;
        for (int r = 0; r < ROWS; r++)
        begin
            group[r] = |rb_pad[r*GROUP_SIZE +: GROUP_SIZE];
        end
        for (int r = ROWS - 1; r >= 0; r--)
        begin
            if (group[r])
            begin
                row = r;
            end
        end
        row_byte = rb_pad[row*GROUP_SIZE +: GROUP_SIZE];
        for (int b = GROUP_SIZE - 1; b >= 0; b--)
        begin
            if (row_byte[b])
            begin
                bitpos = b;
            end
        end
        best_prio = PW'(row * GROUP_SIZE + bitpos);
    end

    always_comb
    begin
        logic [IW-1:0] tix;
        logic          bad_tid;
        logic [PW-1:0] psat;
        logic [TW-1:0] lnk;
        logic          pr_ok;
        logic          nx_ok;
        tix     = IW'(tid_reg);
        bad_tid = 32'(tid_reg) >= MAX_TASKS;
        psat    = (32'(preq_reg) >= NUM_PRIORITIES) ? PW'(NUM_PRIORITIES - 1)
                                                    : PW'(preq_reg);
        lnk     = '0;
        pr_ok   = pr_reg < NIL;
        nx_ok   = nx_reg < NIL;

        state_next     = state_reg;
        ret_next       = ret_reg;
        mode_next      = mode_reg;
        tid_next       = tid_reg;
        preq_next      = preq_reg;
        wake_next      = wake_reg;
        now_next       = now_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        ta_next        = ta_reg;
        pa_next        = pa_reg;
        pr_next        = pr_reg;
        nx_next        = nx_reg;
        scan_next      = scan_reg;
        from_head_next = from_head_reg;
        sw_next        = sw_reg;
        chosen_next    = chosen_reg;
        stat_next      = stat_reg;
        rb_next        = rb_reg;
        st_next        = st_reg;

        head_we = 1'b0; head_wa = pa_reg; head_wd = '0;
        tail_we = 1'b0; tail_wa = pa_reg; tail_wd = '0;
        next_we = 1'b0; next_wa = ta_reg; next_wd = '0;
        prev_we = 1'b0; prev_wa = ta_reg; prev_wd = '0;
        prio_we = 1'b0; prio_wa = ta_reg; prio_wd = '0;
        wake_we = 1'b0; wake_wa = ta_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next   = mode;
                    tid_next    = task_id;
                    preq_next   = priority_req;
                    wake_next   = wake_time;
                    now_next    = now;
                    prev_next   = cur_reg;
                    sw_next     = 1'b0;
                    chosen_next = '0;
                    stat_next   = STAT_OK;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_FIN;
                ret_next   = S_FIN;
                ta_next    = tix;
                pa_next    = psat;
                if (mode_reg <= MODE_SLEEP && bad_tid)
                begin
                    stat_next = STAT_BAD_TASK;
                end
                else
                begin
                    case (mode_reg)
                        MODE_INIT:
                        begin
                            rb_next = '0;
                            for (int i = 0; i < MAX_TASKS; i++)
                            begin
                                st_next[i] = TS_INACTIVE;
                            end
                            prio_we    = 1'b1;
                            prio_wa    = tix;
                            prio_wd    = psat;
                            cur_next   = tix;
                            state_next = S_PT_RD;
                        end
                        MODE_ATTACH, MODE_UNBLOCK:
                        begin
                            if (st_reg[tix] != TS_INACTIVE)
                            begin
                                stat_next = STAT_BAD_TASK;
                            end
                            else
                            begin
                                prio_we    = 1'b1;
                                prio_wa    = tix;
                                prio_wd    = psat;
                                state_next = (mode_reg == MODE_ATTACH) ? S_PT_RD : S_PH_RD;
                            end
                        end
                        MODE_DETACH:
                        begin
                            if (st_reg[tix] == TS_READY)
                            begin
                                st_next[tix] = TS_INACTIVE;
                                state_next   = S_UL_RD;
                            end
                            else if (st_reg[tix] == TS_SLEEP)
                            begin
                                st_next[tix] = TS_INACTIVE;
                            end
                            else
                            begin
                                stat_next = STAT_BAD_TASK;
                            end
                        end
                        MODE_SLEEP:
                        begin
                            if (st_reg[tix] == TS_READY)
                            begin
                                st_next[tix] = TS_SLEEP;
                                wake_we      = 1'b1;
                                wake_wa      = tix;
                                state_next   = S_UL_RD;
                            end
                            else if (st_reg[tix] == TS_SLEEP)
                            begin
                                wake_we = 1'b1;
                                wake_wa = tix;
                            end
                            else
                            begin
                                stat_next = STAT_BAD_TASK;
                            end
                        end
                        MODE_SCHEDULE:
                        begin
                            scan_next  = '0;
                            state_next = S_SC_CHK;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_PT_RD:
            begin
                state_next = S_PT_WR;
            end
            S_PT_WR:
            begin
                lnk     = rb_reg[pa_reg] ? tail_q : NIL;
                prev_we = 1'b1;
                prev_wa = ta_reg;
                prev_wd = lnk;
                tail_we = 1'b1;
                tail_wd = TW'(ta_reg);
                if (lnk < NIL)
                begin
                    next_we = 1'b1;
                    next_wa = IW'(lnk);
                    next_wd = TW'(ta_reg);
                end
                else
                begin
                    head_we = 1'b1;
                    head_wd = TW'(ta_reg);
                end
                state_next = S_PT_LNK;
            end
            S_PT_LNK:
            begin
                next_we          = 1'b1;
                next_wa          = ta_reg;
                next_wd          = NIL;
                st_next[ta_reg]  = TS_READY;
                rb_next[pa_reg]  = 1'b1;
                state_next       = ret_reg;
            end
            S_PH_RD:
            begin
                state_next = S_PH_WR;
            end
            S_PH_WR:
            begin
                lnk     = rb_reg[pa_reg] ? head_q : NIL;
                next_we = 1'b1;
                next_wa = ta_reg;
                next_wd = lnk;
                head_we = 1'b1;
                head_wd = TW'(ta_reg);
                if (lnk < NIL)
                begin
                    prev_we = 1'b1;
                    prev_wa = IW'(lnk);
                    prev_wd = TW'(ta_reg);
                end
                else
                begin
                    tail_we = 1'b1;
                    tail_wd = TW'(ta_reg);
                end
                state_next = S_PH_LNK;
            end
            S_PH_LNK:
            begin
                prev_we         = 1'b1;
                prev_wa         = ta_reg;
                prev_wd         = NIL;
                st_next[ta_reg] = TS_READY;
                rb_next[pa_reg] = 1'b1;
                state_next      = ret_reg;
            end
            S_UL_RD:
            begin
                state_next = S_UL_LAT;
            end
            S_UL_LAT:
            begin
                pa_next    = prio_q;
                pr_next    = prev_q;
                nx_next    = next_q;
                state_next = S_UL_WR;
            end
            S_UL_WR:
            begin
                if (pr_ok)
                begin
                    next_we = 1'b1;
                    next_wa = IW'(pr_reg);
                    next_wd = nx_ok ? nx_reg : NIL;
                end
                else
                begin
                    head_we = 1'b1;
                    head_wd = nx_ok ? nx_reg : NIL;
                end
                if (nx_ok)
                begin
                    prev_we = 1'b1;
                    prev_wa = IW'(nx_reg);
                    prev_wd = pr_ok ? pr_reg : NIL;
                end
                else
                begin
                    tail_we = 1'b1;
                    tail_wd = pr_ok ? pr_reg : NIL;
                end
                if (!pr_ok && !nx_ok)
                begin
                    rb_next[pa_reg] = 1'b0;
                end
                if (mode_reg == MODE_SCHEDULE)
                begin
                    ret_next   = S_FIN;
                    state_next = S_PT_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SC_CHK:
            begin
                if (st_reg[scan_reg] == TS_SLEEP)
                begin
                    ta_next    = scan_reg;
                    state_next = S_SC_RD;
                end
                else
                begin
                    state_next = S_SC_INC;
                end
            end
            S_SC_RD:
            begin
                state_next = S_SC_CMP;
            end
            S_SC_CMP:
            begin
                if (wake_q < now_reg)
                begin
                    pa_next    = prio_q;
                    ret_next   = S_SC_INC;
                    state_next = S_PT_RD;
                end
                else
                begin
                    state_next = S_SC_INC;
                end
            end
            S_SC_INC:
            begin
                if (scan_reg == IW'(MAX_TASKS - 1))
                begin
                    state_next = S_LOOK;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_SC_CHK;
                end
            end
            S_LOOK:
            begin
                if (rb_reg == '0)
                begin
                    stat_next  = STAT_NO_READY;
                    state_next = S_FIN;
                end
                else
                begin
                    pa_next        = best_prio;
                    chosen_next    = best_prio;
                    from_head_next = 1'b1;
                    state_next     = S_SEL_RD;
                end
            end
            S_SEL_RD:
            begin
                state_next = S_SEL_CHK;
            end
            S_SEL_CHK:
            begin
                lnk = from_head_reg ? head_q : next_q;
                if (lnk >= NIL)
                begin
                    stat_next  = STAT_NO_READY;
                    state_next = S_FIN;
                end
                else if (lnk == TW'(cur_reg))
                begin
                    ta_next        = IW'(lnk);
                    from_head_next = 1'b0;
                    state_next     = S_SEL_RD;
                end
                else
                begin
                    cur_next   = IW'(lnk);
                    ta_next    = IW'(lnk);
                    sw_next    = 1'b1;
                    state_next = S_UL_RD;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_FIN;
            cur_reg   <= '0;
            rb_reg    <= '0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                st_reg[i] <= TS_INACTIVE;
            end
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cur_reg   <= cur_next;
            rb_reg    <= rb_next;
            st_reg    <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        tid_reg       <= tid_next;
        preq_reg      <= preq_next;
        wake_reg      <= wake_next;
        now_reg       <= now_next;
        prev_reg      <= prev_next;
        ta_reg        <= ta_next;
        pa_reg        <= pa_next;
        pr_reg        <= pr_next;
        nx_reg        <= nx_next;
        scan_reg      <= scan_next;
        from_head_reg <= from_head_next;
        sw_reg        <= sw_next;
        chosen_reg    <= chosen_next;
        stat_reg      <= stat_next;
    end

    assign busy            = state_reg != S_IDLE;
    assign done            = state_reg == S_FIN;
    assign switched        = sw_reg;
    assign active_task     = 5'(cur_reg);
    assign prev_task       = 5'(prev_reg);
    assign chosen_priority = 6'(chosen_reg);
    assign status          = stat_reg;

endmodule
`default_nettype wire

FILE: sv/pbts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Priority bitmap task scheduler checker
// Port-level properties of the command handshake and the result codes.
// ----------------------------------------------------------------------------
module pbts_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 done,
    input wire logic                 switched,
    input wire logic [4:0]           active_task,
    input wire logic [4:0]           prev_task,
    input wire logic [1:0]           status
);
    import pbts_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not raise busy");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && switched |-> status == STAT_OK && active_task != prev_task)
        else $error("switch reported with bad status or same task");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status == STAT_OK || status == STAT_NO_READY || status == STAT_BAD_TASK)
        else $error("undefined status code");

endmodule

bind priority_bitmap_task_scheduler pbts_checker u_pbts_checker (.*);
`default_nettype wire

FILE: tb/sv/pbts_checker.sv
// ----------------------------------------------------------------------------
// Scheduler result checker
// Watches the command and result transfers, keeps its own copy of the ready
// queues, bitmaps and sleep set, and compares every result with its forecast.
// ----------------------------------------------------------------------------
module pbts_scoreboard (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [2:0]  mode,
    input  wire logic [4:0]  task_id,
    input  wire logic [5:0]  priority_req,
    input  wire logic [47:0] wake_time,
    input  wire logic [47:0] now,
    input  wire logic        done,
    input  wire logic        switched,
    input  wire logic [4:0]  active_task,
    input  wire logic [4:0]  prev_task,
    input  wire logic [5:0]  chosen_priority,
    input  wire logic [1:0]  status,
    output int               fail_count,
    output int               pending
);
    import pbts_pkg::*;

    localparam int NTASK = 32;
    localparam int NPRIO = 64;
    localparam int NIL   = 32;

    typedef struct packed {
        logic       switched;
        logic [4:0] active_task;
        logic [4:0] prev_task;
        logic [5:0] chosen_priority;
        logic [1:0] status;
    } sched_result_t;

    sched_result_t result_q[$];
    int            fails = 0;

    logic [7:0]    grp;
    logic [7:0]    row[8];
    int            head[NPRIO];
    int            tail[NPRIO];
    int            nxt[NTASK];
    int            prv[NTASK];
    logic [5:0]    prio[NTASK];
    task_state_t   tstate[NTASK];
    logic [47:0]   wake[NTASK];
    logic [4:0]    cur;

    assign fail_count = fails;

    function automatic int lowest_bit(logic [7:0] v);
        for (int i = 0; i < 8; i++)
            if (v[i])
                return i;
        return 0;
    endfunction

    function automatic void set_ready(int p);
        grp[p / GROUP_SIZE]      = 1'b1;
        row[p / GROUP_SIZE][p % GROUP_SIZE] = 1'b1;
    endfunction

    function automatic void enqueue_tail(int t, int p);
        prv[t] = tail[p];
        nxt[t] = NIL;
        if (tail[p] < NTASK)
            nxt[tail[p]] = t;
        else
            head[p] = t;
        tail[p]   = t;
        tstate[t] = TS_READY;
        set_ready(p);
    endfunction

    function automatic void enqueue_head(int t, int p);
        nxt[t] = head[p];
        prv[t] = NIL;
        if (head[p] < NTASK)
            prv[head[p]] = t;
        else
            tail[p] = t;
        head[p]   = t;
        tstate[t] = TS_READY;
        set_ready(p);
    endfunction

    function automatic void dequeue(int t);
        int p;
        int pr;
        int nx;
        p  = prio[t];
        pr = prv[t];
        nx = nxt[t];
        if (pr < NTASK)
            nxt[pr] = nx;
        else
            head[p] = nx;
        if (nx < NTASK)
            prv[nx] = pr;
        else
            tail[p] = pr;
        if (head[p] >= NTASK) begin
            row[p / GROUP_SIZE][p % GROUP_SIZE] = 1'b0;
            if (row[p / GROUP_SIZE] == 8'd0)
                grp[p / GROUP_SIZE] = 1'b0;
        end
    endfunction

    function automatic void empty_queues();
        grp = '0;
        for (int i = 0; i < 8; i++)
            row[i] = '0;
        for (int i = 0; i < NPRIO; i++) begin
            head[i] = NIL;
            tail[i] = NIL;
        end
        for (int i = 0; i < NTASK; i++)
            tstate[i] = TS_INACTIVE;
    endfunction

    function automatic sched_result_t predict_event(logic [2:0] m, int t, int p,
                                                    logic [47:0] wt, logic [47:0] tick);
        sched_result_t r;
        int            rw;
        int            best;
        int            c;
        r = '0;
        r.prev_task = cur;
        r.status    = STAT_OK;
        case (m)
            MODE_INIT: begin
                empty_queues();
                prio[t] = 6'(p);
                enqueue_tail(t, p);
                cur = 5'(t);
            end
            MODE_ATTACH, MODE_UNBLOCK: begin
                if (tstate[t] != TS_INACTIVE) begin
                    r.status = STAT_BAD_TASK;
                end else begin
                    prio[t] = 6'(p);
                    if (m == MODE_ATTACH)
                        enqueue_tail(t, p);
                    else
                        enqueue_head(t, p);
                end
            end
            MODE_DETACH: begin
                if (tstate[t] == TS_READY) begin
                    dequeue(t);
                    tstate[t] = TS_INACTIVE;
                end else if (tstate[t] == TS_SLEEP) begin
                    tstate[t] = TS_INACTIVE;
                end else begin
                    r.status = STAT_BAD_TASK;
                end
            end
            MODE_SLEEP: begin
                if (tstate[t] == TS_READY) begin
                    dequeue(t);
                    tstate[t] = TS_SLEEP;
                    wake[t]   = wt;
                end else if (tstate[t] == TS_SLEEP) begin
                    wake[t] = wt;
                end else begin
                    r.status = STAT_BAD_TASK;
                end
            end
            MODE_SCHEDULE: begin
                for (int i = 0; i < NTASK; i++)
                    if (tstate[i] == TS_SLEEP && wake[i] < tick)
                        enqueue_tail(i, prio[i]);
                if (grp == 8'd0) begin
                    r.status = STAT_NO_READY;
                end else begin
                    rw   = lowest_bit(grp);
                    best = rw * GROUP_SIZE + lowest_bit(row[rw]);
                    r.chosen_priority = 6'(best);
                    c = head[best];
                    while (c < NTASK && c == cur)
                        c = nxt[c];
                    if (c < NTASK) begin
                        cur = 5'(c);
                        dequeue(c);
                        enqueue_tail(c, best);
                        r.switched = 1'b1;
                    end else begin
                        r.status = STAT_NO_READY;
                    end
                end
            end
            default: ;
        endcase
        r.active_task = cur;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n) begin
            empty_queues();
            for (int i = 0; i < NTASK; i++) begin
                nxt[i]  = NIL;
                prv[i]  = NIL;
                prio[i] = '0;
                wake[i] = '0;
            end
            cur = '0;
            result_q.delete();
        end else begin
            if (done) begin
                if (result_q.size() == 0) begin
                    $error("result transfer with no expected result");
                    fails++;
                end else begin
                    want = result_q.pop_front();
                    if (switched !== want.switched) begin
                        $error("switched: expected %0d, got %0d", want.switched, switched);
                        fails++;
                    end
                    if (active_task !== want.active_task) begin
                        $error("active_task: expected %0d, got %0d",
                               want.active_task, active_task);
                        fails++;
                    end
                    if (prev_task !== want.prev_task) begin
                        $error("prev_task: expected %0d, got %0d",
                               want.prev_task, prev_task);
                        fails++;
                    end
                    if (chosen_priority !== want.chosen_priority) begin
                        $error("chosen_priority: expected %0d, got %0d",
                               want.chosen_priority, chosen_priority);
                        fails++;
                    end
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fails++;
                    end
                end
            end
            if (start && !busy)
                result_q.push_back(predict_event(mode, task_id, priority_req,
                                                 wake_time, now));
        end
        pending = result_q.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Priority bitmap task scheduler testbench
// Drives directed and random scheduler events with random gaps between
// transfers; the checker forecasts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import pbts_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  mode = '0;
    logic [4:0]  task_id = '0;
    logic [5:0]  priority_req = '0;
    logic [47:0] wake_time = '0;
    logic [47:0] now = '0;
    logic        done;
    logic        switched;
    logic [4:0]  active_task;
    logic [4:0]  prev_task;
    logic [5:0]  chosen_priority;
    logic [1:0]  status;
    int          fail_count;
    int          pending;
    logic [47:0] tick = 48'd100;

    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    priority_bitmap_task_scheduler dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .task_id(task_id), .priority_req(priority_req),
        .wake_time(wake_time), .now(now), .done(done), .switched(switched),
        .active_task(active_task), .prev_task(prev_task),
        .chosen_priority(chosen_priority), .status(status)
    );

    pbts_scoreboard u_scoreboard (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .task_id(task_id), .priority_req(priority_req),
        .wake_time(wake_time), .now(now), .done(done), .switched(switched),
        .active_task(active_task), .prev_task(prev_task),
        .chosen_priority(chosen_priority), .status(status),
        .fail_count(fail_count), .pending(pending)
    );

    task automatic send_event(logic [2:0] m, logic [4:0] t, logic [5:0] p,
                              logic [47:0] wt, logic [47:0] tk);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode         <= m;
        task_id      <= t;
        priority_req <= p;
        wake_time    <= wt;
        now          <= tk;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [47:0] rand_time();
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic random_event();
        int          pick;
        logic [4:0]  t;
        logic [5:0]  p;
        logic [47:0] wt;
        pick = $urandom_range(0, 99);
        t = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 7));
        p = ($urandom_range(0, 4) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 3));
        wt = ($urandom_range(0, 9) == 0) ? rand_time() : tick + $urandom_range(0, 60);
        tick = tick + $urandom_range(0, 20);
        if ($urandom_range(0, 49) == 0)
            tick = rand_time();
        if (pick < 1)
            send_event(MODE_INIT, t, p, rand_time(), rand_time());
        else if (pick < 25)
            send_event(MODE_ATTACH, t, p, rand_time(), rand_time());
        else if (pick < 35)
            send_event(MODE_UNBLOCK, t, p, rand_time(), rand_time());
        else if (pick < 47)
            send_event(MODE_DETACH, t, p, rand_time(), rand_time());
        else if (pick < 62)
            send_event(MODE_SLEEP, t, p, wt, rand_time());
        else if (pick < 98)
            send_event(MODE_SCHEDULE, t, p, rand_time(), tick);
        else if (pick < 99)
            send_event(MODE_SPARE6, t, p, rand_time(), rand_time());
        else
            send_event(MODE_SPARE7, t, p, rand_time(), rand_time());
    endtask

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_event(MODE_SCHEDULE, 5'd0, 6'd0, '0, '0);
        send_event(MODE_ATTACH, 5'd31, 6'd63, '0, '0);
        send_event(MODE_INIT, 5'd31, 6'd63, TIME_MAX, TIME_MAX);
        send_event(MODE_SCHEDULE, 5'd0, 6'd0, '0, '0);
        send_event(MODE_ATTACH, 5'd1, 6'd0, '0, '0);
        send_event(MODE_ATTACH, 5'd2, 6'd0, '0, '0);
        send_event(MODE_UNBLOCK, 5'd3, 6'd0, '0, '0);
        send_event(MODE_ATTACH, 5'd1, 6'd5, '0, '0);
        send_event(MODE_SCHEDULE, 5'd0, 6'd0, '0, 48'd1);
        send_event(MODE_SCHEDULE, 5'd0, 6'd0, '0, 48'd1);
        send_event(MODE_SLEEP, 5'd2, 6'd0, TIME_MAX, '0);
        send_event(MODE_SLEEP, 5'd2, 6'd0, 48'd10, '0);
        send_event(MODE_SLEEP, 5'd4, 6'd0, 48'd10, '0);
        send_event(MODE_SLEEP, 5'd1, 6'd0, '0, '0);
        send_event(MODE_SCHEDULE, 5'd0, 6'd0, '0, 48'd10);
        send_event(MODE_SCHEDULE, 5'd0, 6'd0, '0, TIME_MAX);
        send_event(MODE_DETACH, 5'd2, 6'd0, '0, '0);
        send_event(MODE_SLEEP, 5'd3, 6'd0, '0, '0);
        send_event(MODE_DETACH, 5'd3, 6'd0, '0, '0);
        send_event(MODE_DETACH, 5'd3, 6'd0, '0, '0);
        send_event(MODE_DETACH, 5'd31, 6'd0, '0, '0);
        send_event(MODE_SCHEDULE, 5'd0, 6'd0, '0, TIME_MAX);
        send_event(MODE_SPARE6, 5'd31, 6'd63, TIME_MAX, TIME_MAX);
        send_event(MODE_SPARE7, 5'd0, 6'd0, '0, '0);
        repeat (1800)
            random_event();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/pbts_pkg.sv
sv/pbts_ram.sv
sv/priority_bitmap_task_scheduler.sv
sv/pbts_checker.sv
tb/sv/pbts_checker.sv
tb/sv/tb_top.sv
